[rtl/wavevector_to_polar_dispersion_top_defines.svh]
// Assertion macros for the polar dispersion RTL.
// Included by the top file, which checks its own pipeline invariants.
`ifndef WAVEVECTOR_TO_POLAR_DISPERSION_TOP_DEFINES_SVH
`define WAVEVECTOR_TO_POLAR_DISPERSION_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define WPD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WPD_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WPD_ASSERT(label, clk, rst_n, prop, msg)
`define WPD_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[rtl/wpd_pkg.sv]
// Types, constants and the arctangent table for the polar dispersion block.
// Used by wpd_cordic, wpd_sqrt and the top module; depends on nothing.
package wpd_pkg;

	localparam int ITERATIONS_DEF = 16;
	localparam int STEP_LIMIT     = 24;
	// CORDIC datapath: Q.20, input 24 bits scaled by 16, growth up to 1.65x plus sign
	localparam int XW = 30;
	localparam int ZW = 34;
	localparam int GRAV_W = 24;
	localparam int ADDR_W = 1;

	localparam logic [ZW-1:0] PI_Q30 = 34'sd3373259426;
	localparam logic [29:0] GAIN_Q30 = 30'd652032874;
	localparam logic signed [18:0] DIR_MAX = 19'sd205888;
	localparam logic [GRAV_W-1:0] GRAVITY_RESET = 24'd642689;
	localparam logic [ADDR_W-1:0] REG_GRAVITY = 1'b0;

	typedef struct packed {
		logic signed [23:0] wave_x;
		logic signed [23:0] wave_y;
	} in_item_t;

	typedef struct packed {
		logic signed [18:0] direction;
		logic [23:0] omega;
	} out_item_t;

	function automatic logic [ZW-1:0] atan_q30(input int i);
		logic [ZW-1:0] r;
		case (i)
			0: r = 34'd843314857;
			1: r = 34'd497837829;
			2: r = 34'd263043837;
			3: r = 34'd133525159;
			4: r = 34'd67021687;
			5: r = 34'd33543516;
			6: r = 34'd16775851;
			7: r = 34'd8388437;
			8: r = 34'd4194283;
			9: r = 34'd2097149;
			default: r = ZW'(34'd1 << (30 - i));
		endcase
		return r;
	endfunction

endpackage

[rtl/wpd_cordic.sv]
// Unrolled CORDIC vectoring pipeline, one rotation per register stage.
// Depends on wpd_pkg.
module wpd_cordic import wpd_pkg::*; #(
	parameter int ITERATIONS = ITERATIONS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic signed [XW-1:0] in_x,
	input  logic signed [XW-1:0] in_y,
	input  logic signed [ZW-1:0] in_z,
	input  logic                 in_zero,
	output logic                 out_valid,
	output logic signed [XW-1:0] out_x,
	output logic signed [ZW-1:0] out_z,
	output logic                 out_zero
);

	localparam int STEPS = (ITERATIONS > STEP_LIMIT) ? STEP_LIMIT : ITERATIONS;

	logic                 v_s1 [STEPS+1];
	logic signed [XW-1:0] x_s1 [STEPS+1];
	logic signed [XW-1:0] y_s1 [STEPS+1];
	logic signed [ZW-1:0] z_s1 [STEPS+1];
	logic                 zr_s1 [STEPS+1];

	assign v_s1[0]  = in_valid;
	assign x_s1[0]  = in_x;
	assign y_s1[0]  = in_y;
	assign z_s1[0]  = in_z;
	assign zr_s1[0] = in_zero;

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1[i+1] <= 1'b0;
			end else begin
				v_s1[i+1] <= v_s1[i];
			end
		end
		always_ff @(posedge clk) begin
			zr_s1[i+1] <= zr_s1[i];
			if (y_s1[i] >= 0) begin
				x_s1[i+1] <= x_s1[i] + (y_s1[i] >>> i);
				y_s1[i+1] <= y_s1[i] - (x_s1[i] >>> i);
				z_s1[i+1] <= z_s1[i] + atan_q30(i);
			end else begin
				x_s1[i+1] <= x_s1[i] - (y_s1[i] >>> i);
				y_s1[i+1] <= y_s1[i] + (x_s1[i] >>> i);
				z_s1[i+1] <= z_s1[i] - atan_q30(i);
			end
		end
	end

	assign out_valid = v_s1[STEPS];
	assign out_x     = x_s1[STEPS];
	assign out_z     = z_s1[STEPS];
	assign out_zero  = zr_s1[STEPS];

endmodule

[rtl/wpd_sqrt.sv]
// Pipelined 64-bit integer square root, two result bits per stage.
// Depends on wpd_pkg.
module wpd_sqrt import wpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [63:0] in_op,
	input  logic [18:0] in_dir,
	output logic        out_valid,
	output logic [31:0] out_root,
	output logic [18:0] out_dir
);

	localparam int NST = 16;

	logic        v_s1 [NST+1];
	logic [63:0] op_s1 [NST+1];
	logic [63:0] res_s1 [NST+1];
	logic [18:0] dir_s1 [NST+1];

	assign v_s1[0]   = in_valid;
	assign op_s1[0]  = in_op;
	assign res_s1[0] = '0;
	assign dir_s1[0] = in_dir;

	for (genvar s = 0; s < NST; s++) begin : g_st
		logic [63:0] op_m, res_m, op_n, res_n;
		always_comb begin
			op_m  = op_s1[s];
			res_m = res_s1[s];
			for (int k = 0; k < 2; k++) begin
				if (op_m >= res_m + (64'd1 << (62 - 2*(2*s+k)))) begin
					op_m  = op_m - (res_m + (64'd1 << (62 - 2*(2*s+k))));
					res_m = (res_m >> 1) + (64'd1 << (62 - 2*(2*s+k)));
				end else begin
					res_m = res_m >> 1;
				end
			end
			op_n  = op_m;
			res_n = res_m;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1[s+1] <= 1'b0;
			end else begin
				v_s1[s+1] <= v_s1[s];
			end
		end
		always_ff @(posedge clk) begin
			op_s1[s+1]  <= op_n;
			res_s1[s+1] <= res_n;
			dir_s1[s+1] <= dir_s1[s];
		end
	end

	assign out_valid = v_s1[NST];
	assign out_root  = res_s1[NST][31:0];
	assign out_dir   = dir_s1[NST];

endmodule

[rtl/wavevector_to_polar_dispersion_top.sv]
// Path: fold, CORDIC, gain, gravity, square root, output; one item per cycle.
// Throughput is set by the unrolled CORDIC and square-root pipelines: busy stays low.
// Results appear for one cycle with done high; the receiver cannot stall.
// Reset clears all valid bits and loads gravity with 9.80665 in Q8.16.
// Depends on wpd_pkg, wpd_cordic, wpd_sqrt and the assertion macro header.
`include "wavevector_to_polar_dispersion_top_defines.svh"
module wavevector_to_polar_dispersion_top import wpd_pkg::*; #(
	parameter int ITERATIONS = ITERATIONS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  in_item_t          in_item,
	output logic              done,
	output out_item_t         out_item,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W+1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [GRAV_W-1:0] gravity_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q <= GRAVITY_RESET;
		end else if (wr_en && paddr[ADDR_W+1:2] == REG_GRAVITY) begin
			gravity_q <= pwdata[GRAV_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[ADDR_W+1:2] == REG_GRAVITY) begin
			prdata = {8'd0, gravity_q};
		end
	end

	// stage 0: fold left half plane, seed angle
	logic                 v_s1, zero_s1;
	logic signed [XW-1:0] x_s1, y_s1;
	logic signed [ZW-1:0] z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		zero_s1 <= (in_item.wave_x == 0) && (in_item.wave_y == 0);
		if (in_item.wave_x < 0) begin
			x_s1 <= -(XW'(in_item.wave_x) <<< 4);
			y_s1 <= -(XW'(in_item.wave_y) <<< 4);
			z_s1 <= (in_item.wave_y >= 0) ? $signed(PI_Q30) : -$signed(PI_Q30);
		end else begin
			x_s1 <= XW'(in_item.wave_x) <<< 4;
			y_s1 <= XW'(in_item.wave_y) <<< 4;
			z_s1 <= '0;
		end
	end

	logic                 cv;
	logic signed [XW-1:0] cx;
	logic signed [ZW-1:0] cz;
	logic                 czero;

	wpd_cordic #(.ITERATIONS(ITERATIONS)) u_cordic (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s1), .in_x(x_s1), .in_y(y_s1), .in_z(z_s1), .in_zero(zero_s1),
		.out_valid(cv), .out_x(cx), .out_z(cz), .out_zero(czero)
	);

	// gain multiply and direction rounding
	logic                 v_s2, zero_s2;
	logic signed [63:0]   gp_s2;
	logic signed [18:0]   dir_s2;
	logic signed [ZW-1:0] zr;
	logic signed [ZW-15:0] dfull;

	always_comb begin
		zr    = cz + ZW'(8192);
		dfull = (ZW-14)'(zr >>> 14);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= cv;
		end
	end

	always_ff @(posedge clk) begin
		zero_s2 <= czero;
		gp_s2   <= 64'(cx) * $signed({1'b0, GAIN_Q30});
		if (dfull > 20'(DIR_MAX)) begin
			dir_s2 <= DIR_MAX;
		end else if (dfull < -20'(DIR_MAX)) begin
			dir_s2 <= -DIR_MAX;
		end else begin
			dir_s2 <= dfull[18:0];
		end
	end

	// magnitude clamp, gravity product
	logic               v_s3;
	logic [18:0]        dir_s3;
	logic [63:0]        prod_s3;
	logic signed [63:0] mag_full;
	logic [29:0]        mag;

	always_comb begin
		mag_full = (gp_s2 + 64'sd536870912) >>> 30;
		mag      = (mag_full < 0 || zero_s2) ? '0 : mag_full[29:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dir_s3  <= zero_s2 ? '0 : dir_s2;
		prod_s3 <= (64'(gravity_q) * 64'(mag)) >> 4;
	end

	logic        sv;
	logic [31:0] root;
	logic [18:0] sdir;

	wpd_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s3), .in_op(prod_s3), .in_dir(dir_s3),
		.out_valid(sv), .out_root(root), .out_dir(sdir)
	);

	// saturate omega and register the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= sv;
		end
	end

	always_ff @(posedge clk) begin
		out_item.direction <= sdir;
		out_item.omega     <= (root > 32'd16777215) ? 24'hFFFFFF : root[23:0];
	end

	`WPD_ASSERT(a_never_busy, clk, arst_n, !busy, "busy raised")
	`WPD_ASSERT(a_done_after_sqrt, clk, arst_n, sv |=> done, "sqrt result dropped")
	`WPD_ASSERT(a_dir_range, clk, arst_n, done |-> (out_item.direction <= DIR_MAX && out_item.direction >= -DIR_MAX), "direction overrange")
	`WPD_ASSERT_NR(a_reset_done, clk, !arst_n |-> !done, "done during reset")

endmodule
